>>> rtl/core/gb11_pkg.sv
`timescale 1ns / 1ps

package gb11_pkg;

    // Window geometry for the fixed kernel.
    localparam int RADIUS     = 5;
    localparam int WIN        = 2 * RADIUS + 1;
    localparam int LINES      = 2 * RADIUS;
    localparam int NUM_WEIGHT = 21;
    localparam int WEIGHT_BITS = 17;
    localparam int DROP_BITS  = 12;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PW    = 4;

    // Configuration register indexes.
    localparam logic REG_OUT_WIDTH  = 1'b0;
    localparam logic REG_OUT_HEIGHT = 1'b1;

    localparam logic [10:0] RST_OUT_WIDTH  = 11'd2038;
    localparam logic [15:0] RST_OUT_HEIGHT = 16'd1080;

    // Result tag that travels alongside the arithmetic pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    // Q0.20 kernel weights in triangular order, index b*(b+1)/2 + a with a <= b.
    function automatic logic [WEIGHT_BITS-1:0] weight(input int idx);
        logic [WEIGHT_BITS-1:0] w;
        case (idx)
            0:  w = 17'd74200;
            1:  w = 17'd59414;
            2:  w = 17'd47575;
            3:  w = 17'd30504;
            4:  w = 17'd24426;
            5:  w = 17'd12541;
            6:  w = 17'd10042;
            7:  w = 17'd8041;
            8:  w = 17'd4128;
            9:  w = 17'd1359;
            10: w = 17'd2120;
            11: w = 17'd1697;
            12: w = 17'd871;
            13: w = 17'd287;
            14: w = 17'd61;
            15: w = 17'd287;
            16: w = 17'd230;
            17: w = 17'd118;
            18: w = 17'd39;
            19: w = 17'd8;
            20: w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/gb11_col_cell.sv
`timescale 1ns / 1ps

// One window column. It loads the column from its right neighbor on every
// shift and folds its samples about the center row.
module gb11_col_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_col  [gb11_pkg::WIN],
    output logic [SAMPLE_BITS-1:0] o_col  [gb11_pkg::WIN],
    output logic [SAMPLE_BITS:0]   o_fold [gb11_pkg::RADIUS + 1]
);

    logic [SAMPLE_BITS-1:0] r_col [gb11_pkg::WIN];

    // Column storage, handed to the left neighbor.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // Fold index k pairs rows k and 10-k, so it carries vertical offset 5-k.
    always_comb begin
        for (int k = 0; k < gb11_pkg::RADIUS; k++) begin
            o_fold[k] = {1'b0, r_col[k]} + {1'b0, r_col[gb11_pkg::WIN - 1 - k]};
        end
        o_fold[gb11_pkg::RADIUS] = {1'b0, r_col[gb11_pkg::RADIUS]};
    end

endmodule

>>> rtl/core/gb11_line_store.sv
`timescale 1ns / 1ps

// Ten line memories. A column is read when a sample is accepted and written
// back one line up in the following cycle.
module gb11_line_store #(
    parameter int MAX_LINE    = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(MAX_LINE)-1:0] i_rd_addr,
    output logic [SAMPLE_BITS-1:0]      o_rd_data [gb11_pkg::LINES],
    input  logic                        i_wr_en,
    input  logic [$clog2(MAX_LINE)-1:0] i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]      i_wr_sample
);

    logic [SAMPLE_BITS-1:0] r_rd [gb11_pkg::LINES];

    assign o_rd_data = r_rd;

    for (genvar l = 0; l < gb11_pkg::LINES; l++) begin : g_line
        logic [SAMPLE_BITS-1:0] mem [MAX_LINE];
        logic [SAMPLE_BITS-1:0] w_wr;

        // Each line takes the older content of the line below it.
        if (l == gb11_pkg::LINES - 1) begin : g_top
            assign w_wr = i_wr_sample;
        end else begin : g_mid
            assign w_wr = r_rd[l + 1];
        end

        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                r_rd[l] <= mem[i_rd_addr];
            end
            if (i_wr_en) begin
                mem[i_wr_addr] <= w_wr;
            end
        end
    end

endmodule

>>> rtl/core/gb11_mac.sv
`timescale 1ns / 1ps

// Symmetric kernel sum: quadrant fold, diagonal fold, 21 products, adder
// tree, then truncation and saturation.
module gb11_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gb11_pkg::t_tag           i_tag,
    input  logic [SAMPLE_BITS:0]     i_fold [gb11_pkg::WIN][gb11_pkg::RADIUS + 1],
    output gb11_pkg::t_tag           o_tag,
    output logic [SAMPLE_BITS+7:0]   o_blurred
);

    localparam int QW = SAMPLE_BITS + 2;
    localparam int DW = SAMPLE_BITS + 3;
    localparam int MW = DW + gb11_pkg::WEIGHT_BITS;
    localparam int GW = MW + 2;
    localparam int AW = SAMPLE_BITS + 25;
    localparam int OW = SAMPLE_BITS + 8;
    localparam int NG = gb11_pkg::NUM_WEIGHT / 3;

    gb11_pkg::t_tag r_tag_q, r_tag_d, r_tag_m, r_tag_g, r_tag_a, r_tag_o;

    logic [QW-1:0] r_q [gb11_pkg::RADIUS + 1][gb11_pkg::RADIUS + 1];
    logic [DW-1:0] r_d [gb11_pkg::NUM_WEIGHT];
    logic [MW-1:0] r_m [gb11_pkg::NUM_WEIGHT];
    logic [GW-1:0] r_g [NG];
    logic [AW-1:0] r_acc;
    logic [OW-1:0] r_out;

    logic [QW-1:0] n_q [gb11_pkg::RADIUS + 1][gb11_pkg::RADIUS + 1];
    logic [DW-1:0] n_d [gb11_pkg::NUM_WEIGHT];
    logic [AW-1:0] n_acc;

    // Tag pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_q <= '0;
            r_tag_d <= '0;
            r_tag_m <= '0;
            r_tag_g <= '0;
            r_tag_a <= '0;
            r_tag_o <= '0;
        end else begin
            r_tag_q <= i_tag;
            r_tag_d <= r_tag_q;
            r_tag_m <= r_tag_d;
            r_tag_g <= r_tag_m;
            r_tag_a <= r_tag_g;
            r_tag_o <= r_tag_a;
        end
    end

    // Fold the four mirrored quadrants; q[dx][dy] holds offsets +-dx, +-dy.
    always_comb begin
        for (int dx = 0; dx <= gb11_pkg::RADIUS; dx++) begin
            for (int dy = 0; dy <= gb11_pkg::RADIUS; dy++) begin
                n_q[dx][dy] = QW'(i_fold[gb11_pkg::RADIUS - dx][gb11_pkg::RADIUS - dy]);
                if (dx != 0) begin
                    n_q[dx][dy] = n_q[dx][dy]
                        + QW'(i_fold[gb11_pkg::RADIUS + dx][gb11_pkg::RADIUS - dy]);
                end
            end
        end
    end

    // Fold about the diagonal into the triangular weight order.
    always_comb begin
        for (int b = 0; b <= gb11_pkg::RADIUS; b++) begin
            for (int a = 0; a <= b; a++) begin
                n_d[(b * (b + 1)) / 2 + a] = DW'(r_q[a][b]);
                if (a != b) begin
                    n_d[(b * (b + 1)) / 2 + a] = n_d[(b * (b + 1)) / 2 + a]
                        + DW'(r_q[b][a]);
                end
            end
        end
    end

    // Final sum of the partial groups.
    always_comb begin
        n_acc = '0;
        for (int g = 0; g < NG; g++) begin
            n_acc = n_acc + AW'(r_g[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_d <= n_d;
        // One product per distinct weight.
        for (int t = 0; t < gb11_pkg::NUM_WEIGHT; t++) begin
            r_m[t] <= MW'(r_d[t]) * MW'(gb11_pkg::weight(t));
        end
        // Groups of three products.
        for (int g = 0; g < NG; g++) begin
            r_g[g] <= GW'(r_m[3 * g]) + GW'(r_m[3 * g + 1]) + GW'(r_m[3 * g + 2]);
        end
        r_acc <= n_acc;
        // Drop to Q16.8 and clamp at full scale.
        if (|r_acc[AW-1:OW+gb11_pkg::DROP_BITS]) begin
            r_out <= '1;
        end else begin
            r_out <= r_acc[OW+gb11_pkg::DROP_BITS-1:gb11_pkg::DROP_BITS];
        end
    end

    assign o_tag     = r_tag_o;
    assign o_blurred = r_out;

endmodule

>>> rtl/core/gaussian_blur_11x11_core.sv
`timescale 1ns / 1ps

// Streaming 11x11 Gaussian blur (sigma 1.5). Samples enter in raster order
// over a frame that is the output size plus a five-sample margin on each
// side, one beat per cycle while input ready is high. Ten line memories,
// read when a beat is accepted and written back in the next cycle, feed a
// chain of eleven column cells that hold the window. The kernel sum runs in
// a six-stage pipeline. Results wait in a 16-entry output buffer; input
// ready drops only while 16 results are in flight or waiting, and while
// reset is held. Configuration is to be written only while the block is
// idle; the block itself does not enforce this.
module gaussian_blur_11x11_core #(
    parameter int MAX_LINE    = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [15:0]            i_cfg_data,
    input  logic                   i_sample_valid,
    output logic                   o_sample_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_blur_valid,
    input  logic                   i_blur_ready,
    output logic [SAMPLE_BITS+7:0] o_blurred,
    output logic                   o_frame_last
);

    localparam int AW = $clog2(MAX_LINE);
    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int WW = (CW > 12) ? CW : 12;
    localparam int OW = SAMPLE_BITS + 8;
    localparam int PW = gb11_pkg::FIFO_PW;

    // Configuration registers.
    logic [10:0] r_out_width;
    logic [15:0] r_out_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= gb11_pkg::RST_OUT_WIDTH;
            r_out_height <= gb11_pkg::RST_OUT_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gb11_pkg::REG_OUT_WIDTH:  r_out_width  <= i_cfg_data[10:0];
                gb11_pkg::REG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Position counters.
    logic [CW-1:0] r_col;
    logic [16:0]   r_row;
    logic [CW-1:0] n_col;
    logic [16:0]   n_row;

    logic [WW-1:0] w_in_w, w_w_ext, w_col_a, w_col_inc;
    logic [16:0]   w_in_h;
    logic [17:0]   w_row_a, w_row_b, w_row_inc;
    logic          w_accept, w_prod, w_last;

    assign w_accept = i_sample_valid & o_sample_ready;

    always_comb begin
        w_w_ext = WW'(r_out_width) + WW'(gb11_pkg::LINES);
        w_in_w  = (w_w_ext > WW'(MAX_LINE)) ? WW'(MAX_LINE) : w_w_ext;
        w_in_h  = 17'(r_out_height) + 17'(gb11_pkg::LINES);

        // Close a line or frame that a smaller geometry has already passed.
        if (WW'(r_col) >= w_in_w) begin
            w_col_a = '0;
            w_row_a = 18'(r_row) + 18'd1;
        end else begin
            w_col_a = WW'(r_col);
            w_row_a = 18'(r_row);
        end
        w_row_b = (w_row_a >= 18'(w_in_h)) ? '0 : w_row_a;

        w_prod = (w_row_b >= 18'(gb11_pkg::LINES)) && (w_col_a >= WW'(gb11_pkg::LINES));
        w_col_inc = w_col_a + WW'(1);
        w_row_inc = w_row_b + 18'd1;
        w_last = (w_row_inc == 18'(w_in_h)) && (w_col_inc == w_in_w);

        if (w_col_inc >= w_in_w) begin
            n_col = '0;
            n_row = (w_row_inc >= 18'(w_in_h)) ? '0 : w_row_inc[16:0];
        end else begin
            n_col = w_col_inc[CW-1:0];
            n_row = w_row_b[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage one: memory read data arrives with the beat's sample and flags.
    gb11_pkg::t_tag         r_s1_tag;
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic [AW-1:0]          r_s1_addr;
    gb11_pkg::t_tag         r_s2_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_tag   <= '0;
            r_s2_tag   <= '0;
        end else begin
            r_s1_valid     <= w_accept;
            r_s1_tag.valid <= w_accept & w_prod;
            r_s1_tag.last  <= w_last;
            r_s2_tag       <= r_s1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= i_sample;
            r_s1_addr   <= w_col_a[AW-1:0];
        end
    end

    logic [SAMPLE_BITS-1:0] w_rd [gb11_pkg::LINES];

    gb11_line_store #(
        .MAX_LINE    (MAX_LINE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_rd_en     (w_accept),
        .i_rd_addr   (w_col_a[AW-1:0]),
        .o_rd_data   (w_rd),
        .i_wr_en     (r_s1_valid),
        .i_wr_addr   (r_s1_addr),
        .i_wr_sample (r_s1_sample)
    );

    // Window: a chain of column cells shifting left on every beat.
    logic [SAMPLE_BITS-1:0] w_new_col [gb11_pkg::WIN];
    logic [SAMPLE_BITS-1:0] w_cell_in  [gb11_pkg::WIN][gb11_pkg::WIN];
    logic [SAMPLE_BITS-1:0] w_cell_out [gb11_pkg::WIN][gb11_pkg::WIN];
    logic [SAMPLE_BITS:0]   w_fold [gb11_pkg::WIN][gb11_pkg::RADIUS + 1];

    always_comb begin
        for (int r = 0; r < gb11_pkg::LINES; r++) begin
            w_new_col[r] = w_rd[r];
        end
        w_new_col[gb11_pkg::WIN - 1] = r_s1_sample;
    end

    for (genvar c = 0; c < gb11_pkg::WIN; c++) begin : g_cell
        if (c == gb11_pkg::WIN - 1) begin : g_head
            assign w_cell_in[c] = w_new_col;
        end else begin : g_link
            assign w_cell_in[c] = w_cell_out[c + 1];
        end

        gb11_col_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (r_s1_valid),
            .i_col   (w_cell_in[c]),
            .o_col   (w_cell_out[c]),
            .o_fold  (w_fold[c])
        );
    end

    // Kernel sum.
    gb11_pkg::t_tag  w_mac_tag;
    logic [OW-1:0]   w_mac_out;

    gb11_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (r_s2_tag),
        .i_fold    (w_fold),
        .o_tag     (w_mac_tag),
        .o_blurred (w_mac_out)
    );

    // Output buffer with credit count covering the pipeline.
    logic [OW:0]   r_fifo [gb11_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_fill, r_pend;
    logic          w_pop;

    assign w_pop          = o_blur_valid & i_blur_ready;
    assign o_blur_valid   = (r_fill != '0);
    assign o_sample_ready = i_rst_n & (r_pend < (PW+1)'(gb11_pkg::FIFO_DEPTH));
    assign o_blurred      = r_fifo[r_rd_ptr][OW:1];
    assign o_frame_last   = r_fifo[r_rd_ptr][0];

    always_ff @(posedge i_clk) begin
        if (w_mac_tag.valid) begin
            r_fifo[r_wr_ptr] <= {w_mac_out, w_mac_tag.last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_pend   <= '0;
        end else begin
            if (w_mac_tag.valid) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_fill <= r_fill + (PW+1)'(w_mac_tag.valid) - (PW+1)'(w_pop);
            r_pend <= r_pend + (PW+1)'(w_accept & w_prod) - (PW+1)'(w_pop);
        end
    end

endmodule

>>> dv/tb_gaussian_blur_11x11_core.sv
`timescale 1ns / 1ps

module tb_gaussian_blur_11x11_core;

    localparam int MAX_LINE   = 2048;
    localparam int SETTLE     = 20;
    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;
    localparam int NUM_ITEMS  = 1750;

    // Q0.20 kernel weights in triangular order, b*(b+1)/2 + a.
    localparam int unsigned KERNEL_Q20 [21] = '{
        74200, 59414, 47575, 30504, 24426, 12541, 10042, 8041, 4128, 1359,
        2120, 1697, 871, 287, 61, 287, 230, 118, 39, 8, 1
    };

    typedef struct {
        logic [23:0] blurred;
        logic        last;
    } t_blur_beat;

    // Holds predicted output beats and compares them as they come out.
    class blur_scoreboard;
        t_blur_beat pending_q[$];
        int         errors;
        int         matched;

        function new();
            errors  = 0;
            matched = 0;
        endfunction

        function void note_input(t_blur_beat exp_beat);
            pending_q.push_back(exp_beat);
        endfunction

        function void check_output(logic [23:0] blurred, logic last);
            t_blur_beat exp_beat;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected output beat blurred=%h last=%b",
                         $realtime, blurred, last);
                errors++;
                return;
            end
            exp_beat = pending_q.pop_front();
            if (blurred !== exp_beat.blurred) begin
                $display("%0t: blurred mismatch, expected %h actual %h",
                         $realtime, exp_beat.blurred, blurred);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $display("%0t: frame_last mismatch, expected %b actual %b",
                         $realtime, exp_beat.last, last);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_sample_valid = 1'b0;
    logic        o_sample_ready;
    logic [15:0] i_sample = '0;
    logic        o_blur_valid;
    logic        i_blur_ready = 1'b0;
    logic [23:0] o_blurred;
    logic        o_frame_last;

    gaussian_blur_11x11_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_blur_valid   (o_blur_valid),
        .i_blur_ready   (i_blur_ready),
        .o_blurred      (o_blurred),
        .o_frame_last   (o_frame_last)
    );

    blur_scoreboard sb;

    // Predictor state: geometry, line memories, window and raster position.
    logic [10:0] geo_width;
    logic [15:0] geo_height;
    logic [15:0] line_mem [0:gb11_pkg::LINES*MAX_LINE-1];
    logic [15:0] win [0:gb11_pkg::WIN*gb11_pkg::WIN-1];
    int unsigned col_pos;
    int unsigned row_pos;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int hold_left;
    int samples_in;
    int wdog;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned kernel_tap(int r, int c);
        int dy;
        int dx;
        int a;
        int b;
        dy = (r > gb11_pkg::RADIUS) ? r - gb11_pkg::RADIUS : gb11_pkg::RADIUS - r;
        dx = (c > gb11_pkg::RADIUS) ? c - gb11_pkg::RADIUS : gb11_pkg::RADIUS - c;
        a = (dx < dy) ? dx : dy;
        b = (dx < dy) ? dy : dx;
        return KERNEL_Q20[b * (b + 1) / 2 + a];
    endfunction

    function automatic int unsigned line_len();
        int unsigned w;
        w = geo_width + gb11_pkg::LINES;
        return (w > MAX_LINE) ? MAX_LINE : w;
    endfunction

    // Advances the raster model by one sample and predicts its output beat.
    function automatic void blur_predict(input logic [15:0] s, output bit has_out,
                                         output t_blur_beat beat);
        int unsigned in_w;
        int unsigned in_h;
        int unsigned col;
        int unsigned row;
        longint unsigned acc;
        in_w = line_len();
        in_h = geo_height + gb11_pkg::LINES;
        col = col_pos;
        row = row_pos;
        if (col >= in_w) begin
            col = 0;
            row++;
        end
        if (row >= in_h) row = 0;

        for (int r = 0; r < gb11_pkg::WIN; r++)
            for (int c = 0; c < gb11_pkg::WIN - 1; c++)
                win[r*gb11_pkg::WIN + c] = win[r*gb11_pkg::WIN + c + 1];
        for (int r = 0; r < gb11_pkg::LINES; r++)
            win[r*gb11_pkg::WIN + gb11_pkg::WIN - 1] = line_mem[r*MAX_LINE + col];
        win[gb11_pkg::WIN*gb11_pkg::WIN - 1] = s;
        for (int r = 0; r < gb11_pkg::LINES - 1; r++)
            line_mem[r*MAX_LINE + col] = line_mem[(r + 1)*MAX_LINE + col];
        line_mem[(gb11_pkg::LINES - 1)*MAX_LINE + col] = s;

        has_out = (row >= gb11_pkg::LINES) && (col >= gb11_pkg::LINES);
        beat.blurred = '0;
        beat.last = 1'b0;
        if (has_out) begin
            acc = 0;
            for (int r = 0; r < gb11_pkg::WIN; r++)
                for (int c = 0; c < gb11_pkg::WIN; c++)
                    acc += longint'(win[r*gb11_pkg::WIN + c]) * kernel_tap(r, c);
            acc = acc >> gb11_pkg::DROP_BITS;
            beat.blurred = (acc > 64'hFF_FFFF) ? 24'hFF_FFFF : acc[23:0];
            beat.last = (row + 1 == in_h) && (col + 1 == in_w);
        end

        col++;
        if (col >= in_w) begin
            col = 0;
            row++;
            if (row >= in_h) row = 0;
        end
        col_pos = col;
        row_pos = row & 32'h1FFFF;
    endfunction

    // Output side: random back-pressure, long hold-off on request, checking.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_blur_ready <= 1'b0;
        end else begin
            if (o_blur_valid && i_blur_ready) sb.check_output(o_blurred, o_frame_last);
            if (hold_req != 0) begin
                hold_left = HOLD_LEN;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_blur_ready <= 1'b0;
            end else begin
                i_blur_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((o_blur_valid && i_blur_ready) || (i_sample_valid && o_sample_ready)
            || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_sample(input logic [15:0] s);
        bit         has_out;
        t_blur_beat beat;
        // Idling phases follow the number of samples sent so far.
        if (samples_in < 580) begin
            send_idle_pct = 15;
            recv_idle_pct = 56;
        end else if (samples_in < 1160) begin
            send_idle_pct = 56;
            recv_idle_pct = 15;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_sample_ready);
        blur_predict(s, has_out, beat);
        if (has_out) sb.note_input(beat);
        samples_in++;
    endtask

    // Lets every pending result drain so the registers may be rewritten.
    task automatic drain();
        i_sample_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == gb11_pkg::REG_OUT_WIDTH) geo_width = value[10:0];
        else geo_height = value;
    endtask

    function automatic logic [15:0] pick_sample(int style);
        case (style)
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Feeds samples until the raster position is back at frame start.
    task automatic finish_frame(input int style);
        do send_sample(pick_sample(style)); while (col_pos != 0 || row_pos != 0);
    endtask

    task automatic run_frame(input int w, input int h, input int style);
        drain();
        reg_write(gb11_pkg::REG_OUT_WIDTH, 16'(w));
        reg_write(gb11_pkg::REG_OUT_HEIGHT, 16'(h));
        finish_frame(style);
    endtask

    initial begin
        int w;
        int h;
        int style;
        sb = new();
        geo_width = gb11_pkg::RST_OUT_WIDTH;
        geo_height = gb11_pkg::RST_OUT_HEIGHT;
        col_pos = 0;
        row_pos = 0;
        hold_req = 0;
        hold_left = 0;
        samples_in = 0;
        wdog = 0;
        send_idle_pct = 15;
        recv_idle_pct = 56;
        for (int i = 0; i < gb11_pkg::LINES*MAX_LINE; i++) line_mem[i] = '0;
        for (int i = 0; i < gb11_pkg::WIN*gb11_pkg::WIN; i++) win[i] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full-scale and zero 1x1 frames, then a mixed 3x2 frame.
        run_frame(1, 1, 0);
        run_frame(1, 1, 1);
        run_frame(3, 2, 2);
        // Zero size gives no results; two whole 10x10 frames keep alignment.
        drain();
        reg_write(gb11_pkg::REG_OUT_WIDTH, 16'd0);
        reg_write(gb11_pkg::REG_OUT_HEIGHT, 16'd0);
        repeat (200) send_sample(pick_sample(3));
        // Tallest frame, cut short by shrinking the height mid-frame.
        run_frame(1, 1, 3);
        drain();
        reg_write(gb11_pkg::REG_OUT_HEIGHT, 16'hFFFF);
        repeat (165) send_sample(pick_sample(3));
        drain();
        reg_write(gb11_pkg::REG_OUT_HEIGHT, 16'd1);
        finish_frame(3);
        // Output held off while the result rows stream in, so the input stalls.
        drain();
        reg_write(gb11_pkg::REG_OUT_WIDTH, 16'd20);
        reg_write(gb11_pkg::REG_OUT_HEIGHT, 16'd2);
        repeat (300) send_sample(pick_sample(3));
        hold_req = 1;
        finish_frame(3);

        // Random frames until the item budget is used.
        while (samples_in < NUM_ITEMS) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 8);
            if (w > 40) w = $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            style = ($urandom_range(3) == 0) ? $urandom_range(2) : 3;
            if ($urandom_range(4) == 0) begin
                // Broken frame: stop partway and reshape before finishing.
                drain();
                reg_write(gb11_pkg::REG_OUT_WIDTH, 16'(w));
                reg_write(gb11_pkg::REG_OUT_HEIGHT, 16'(h));
                repeat ($urandom_range(1, (w + 10) * (h + 10) - 1))
                    send_sample(pick_sample(style));
                drain();
                if ($urandom_range(1) && w > 1)
                    reg_write(gb11_pkg::REG_OUT_WIDTH, 16'($urandom_range(1, w - 1)));
                else
                    reg_write(gb11_pkg::REG_OUT_HEIGHT, 16'($urandom_range(1, 6)));
                finish_frame(style);
            end else begin
                run_frame(w, h, style);
            end
        end

        drain();
        $display("Sent %0d samples over directed and random frames, %0d blurred beats checked.",
                 samples_in, sb.matched);
        $display("Geometry covered zero size, minimum size, a cut tall frame and reshaped frames.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/gb11_pkg.sv
rtl/core/gb11_col_cell.sv
rtl/core/gb11_line_store.sv
rtl/core/gb11_mac.sv
rtl/core/gaussian_blur_11x11_core.sv
dv/tb_gaussian_blur_11x11_core.sv
